// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, held off while reset is low
`define ECPAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also holds during reset
`define ECPAD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ecpad_pkg.sv =====
`timescale 1ns / 1ps
package ecpad_pkg;

  localparam int FIELD_BITS = 64;
  localparam int DATA_W     = 64;
  localparam logic [DATA_W-1:0] FIELD_MASK =
    (FIELD_BITS >= DATA_W) ? {DATA_W{1'b1}} : ((DATA_W'(1) << FIELD_BITS) - DATA_W'(1));
  localparam int CNT_W = $clog2(DATA_W + 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(DATA_W);

  // datapath operations
  localparam logic [2:0] OP_MOV = 3'd0;
  localparam logic [2:0] OP_ADD = 3'd1;
  localparam logic [2:0] OP_SUB = 3'd2;
  localparam logic [2:0] OP_MUL = 3'd3;
  localparam logic [2:0] OP_DIV = 3'd4;
  localparam logic [2:0] OP_RED = 3'd5;
  localparam logic [2:0] OP_OUT = 3'd6;

  // operand register selects
  localparam logic [4:0] RI_ZERO = 5'd0;
  localparam logic [4:0] RI_ONE  = 5'd1;
  localparam logic [4:0] RI_M    = 5'd2;
  localparam logic [4:0] RI_A    = 5'd3;
  localparam logic [4:0] RI_B    = 5'd4;
  localparam logic [4:0] RI_PX   = 5'd5;
  localparam logic [4:0] RI_PY   = 5'd6;
  localparam logic [4:0] RI_QX   = 5'd7;
  localparam logic [4:0] RI_QY   = 5'd8;
  localparam logic [4:0] RI_T0   = 5'd9;
  localparam logic [4:0] RI_T1   = 5'd10;
  localparam logic [4:0] RI_T2   = 5'd11;
  localparam logic [4:0] RI_R0   = 5'd12;
  localparam logic [4:0] RI_R1   = 5'd13;
  localparam logic [4:0] RI_U0   = 5'd14;
  localparam logic [4:0] RI_U1   = 5'd15;
  localparam logic [4:0] RI_Q    = 5'd16;
  localparam logic [4:0] RI_TMP  = 5'd17;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_P_OFF = 2'd1;
  localparam logic [1:0] ST_Q_OFF = 2'd2;
  localparam logic [1:0] ST_NOINV = 2'd3;

  typedef struct packed {
    logic       load;
    logic       go;
    logic [2:0] op;
    logic [4:0] dst;
    logic [4:0] s1;
    logic [4:0] s2;
    logic [1:0] res_st;
    logic       res_inf;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic eq;
    logic m_lt2;
  } sts_t;

  // modular add of reduced operands
  function automatic logic [DATA_W-1:0] fadd(input logic [DATA_W-1:0] u,
                                             input logic [DATA_W-1:0] v,
                                             input logic [DATA_W-1:0] m);
    logic [DATA_W:0] s;
    s = {1'b0, u} + {1'b0, v};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[DATA_W-1:0];
  endfunction

  // modular subtract of reduced operands
  function automatic logic [DATA_W-1:0] fsub(input logic [DATA_W-1:0] u,
                                             input logic [DATA_W-1:0] v,
                                             input logic [DATA_W-1:0] m);
    logic [DATA_W-1:0] d;
    d = u - v;
    if (u < v) d = d + m;
    return d;
  endfunction

endpackage

// ===== rtl/elliptic_curve_point_add_double.sv =====
`timescale 1ns / 1ps
// operation: a double or an add runs as a sequence of steps on the shared unit, plus an
//   euclid loop for the inverse; errors end sooner.
//   shared unit: bit-serial multiply, restoring divide/reduce, move/add/sub
// throughput: one word at a time, busy stays high until the result strobe
// result strobe out_valid is one cycle wide, the receiver cannot stall
// reset: synchronous active-low rst_n, configuration registers return to p=65537, a=1, b=1
module elliptic_curve_point_add_double (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_opcode,
  input  logic [63:0] in_p_x,
  input  logic [63:0] in_p_y,
  input  logic        in_p_at_infinity,
  input  logic [63:0] in_q_x,
  input  logic [63:0] in_q_y,
  input  logic        in_q_at_infinity,
  output logic        out_valid,
  output logic [63:0] out_r_x,
  output logic [63:0] out_r_y,
  output logic        out_r_at_infinity,
  output logic [1:0]  out_status,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_MODULUS = 2'd0;
  localparam logic [1:0] REG_COEF_A  = 2'd1;
  localparam logic [1:0] REG_COEF_B  = 2'd2;

  logic [63:0]     cfg_modulus_r, cfg_coef_a_r, cfg_coef_b_r;
  logic            cfg_wr;
  ecpad_pkg::cmd_t cmd;
  ecpad_pkg::sts_t sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_modulus_r <= 64'd65537;
      cfg_coef_a_r  <= 64'd1;
      cfg_coef_b_r  <= 64'd1;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_MODULUS: cfg_modulus_r <= pwdata;
        REG_COEF_A:  cfg_coef_a_r  <= pwdata;
        REG_COEF_B:  cfg_coef_b_r  <= pwdata;
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[4:3])
      REG_MODULUS: prdata = cfg_modulus_r;
      REG_COEF_A:  prdata = cfg_coef_a_r;
      REG_COEF_B:  prdata = cfg_coef_b_r;
      default:     prdata = '0;
    endcase
  end

  ecpad_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .in_opcode        (in_opcode),
    .in_p_at_infinity (in_p_at_infinity),
    .in_q_at_infinity (in_q_at_infinity),
    .busy             (busy),
    .cmd              (cmd),
    .sts              (sts)
  );

  ecpad_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_p_x            (in_p_x),
    .in_p_y            (in_p_y),
    .in_q_x            (in_q_x),
    .in_q_y            (in_q_y),
    .cfg_modulus       (cfg_modulus_r),
    .cfg_coef_a        (cfg_coef_a_r),
    .cfg_coef_b        (cfg_coef_b_r),
    .out_valid         (out_valid),
    .out_r_x           (out_r_x),
    .out_r_y           (out_r_y),
    .out_r_at_infinity (out_r_at_infinity),
    .out_status        (out_status)
  );

endmodule

// ===== rtl/ecpad_dp.sv =====
`timescale 1ns / 1ps
module ecpad_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ecpad_pkg::cmd_t               cmd,
  output ecpad_pkg::sts_t               sts,
  input  logic [ecpad_pkg::DATA_W-1:0]  in_p_x,
  input  logic [ecpad_pkg::DATA_W-1:0]  in_p_y,
  input  logic [ecpad_pkg::DATA_W-1:0]  in_q_x,
  input  logic [ecpad_pkg::DATA_W-1:0]  in_q_y,
  input  logic [ecpad_pkg::DATA_W-1:0]  cfg_modulus,
  input  logic [ecpad_pkg::DATA_W-1:0]  cfg_coef_a,
  input  logic [ecpad_pkg::DATA_W-1:0]  cfg_coef_b,
  output logic                          out_valid,
  output logic [ecpad_pkg::DATA_W-1:0]  out_r_x,
  output logic [ecpad_pkg::DATA_W-1:0]  out_r_y,
  output logic                          out_r_at_infinity,
  output logic [1:0]                    out_status
);

  localparam int W = ecpad_pkg::DATA_W;

  logic [W-1:0] m_r, a_r, b_r, px_r, py_r, qx_r, qy_r;
  logic [W-1:0] t0_r, t1_r, t2_r, r0_r, r1_r, u0_r, u1_r, q_r, tmp_r;

  // unit registers
  logic                        run_r, done_r, ph_r;
  logic [2:0]                  op_r;
  logic [4:0]                  dst_r;
  logic [W-1:0]                num_r, den_r, rem_r;
  logic [ecpad_pkg::CNT_W-1:0] cnt_r;

  logic [W-1:0] v1, v2, res;
  logic         wr_en, wr_q;
  logic [W:0]   div_t;
  logic         div_ge;

  logic         ov_r, oinf_r;
  logic [1:0]   ost_r;
  logic [W-1:0] ox_r, oy_r;

  function automatic logic [W-1:0] pick(input logic [4:0] idx);
    logic [W-1:0] v;
    case (idx)
      ecpad_pkg::RI_ZERO: v = '0;
      ecpad_pkg::RI_ONE:  v = W'(1);
      ecpad_pkg::RI_M:    v = m_r;
      ecpad_pkg::RI_A:    v = a_r;
      ecpad_pkg::RI_B:    v = b_r;
      ecpad_pkg::RI_PX:   v = px_r;
      ecpad_pkg::RI_PY:   v = py_r;
      ecpad_pkg::RI_QX:   v = qx_r;
      ecpad_pkg::RI_QY:   v = qy_r;
      ecpad_pkg::RI_T0:   v = t0_r;
      ecpad_pkg::RI_T1:   v = t1_r;
      ecpad_pkg::RI_T2:   v = t2_r;
      ecpad_pkg::RI_R0:   v = r0_r;
      ecpad_pkg::RI_R1:   v = r1_r;
      ecpad_pkg::RI_U0:   v = u0_r;
      ecpad_pkg::RI_U1:   v = u1_r;
      ecpad_pkg::RI_Q:    v = q_r;
      ecpad_pkg::RI_TMP:  v = tmp_r;
      default:            v = '0;
    endcase
    return v;
  endfunction

  // operand selection and status
  always_comb begin
    v1 = pick(cmd.s1);
    v2 = pick(cmd.s2);
    sts.eq    = (v1 == v2);
    sts.m_lt2 = (m_r < W'(2));
    sts.done  = done_r;
  end

  // one restoring division step
  always_comb begin
    div_t  = {rem_r, num_r[W-1]};
    div_ge = (div_t >= {1'b0, den_r});
  end

  // write-back of a finished operation
  always_comb begin
    wr_en = 1'b0;
    wr_q  = 1'b0;
    res   = '0;
    if (run_r) begin
      case (op_r)
        ecpad_pkg::OP_MOV: begin
          wr_en = 1'b1;
          res   = num_r;
        end
        ecpad_pkg::OP_ADD: begin
          wr_en = 1'b1;
          res   = ecpad_pkg::fadd(num_r, den_r, m_r);
        end
        ecpad_pkg::OP_SUB: begin
          wr_en = 1'b1;
          res   = ecpad_pkg::fsub(num_r, den_r, m_r);
        end
        ecpad_pkg::OP_MUL, ecpad_pkg::OP_RED: begin
          wr_en = (cnt_r == ecpad_pkg::CNT_END);
          res   = rem_r;
        end
        ecpad_pkg::OP_DIV: begin
          wr_en = (cnt_r == ecpad_pkg::CNT_END);
          wr_q  = wr_en;
          res   = rem_r;
        end
        default: ;
      endcase
    end
  end

  // iterative unit control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      ov_r   <= 1'b0;
      if (cmd.go) begin
        if (cmd.op == ecpad_pkg::OP_OUT) begin
          ov_r   <= 1'b1;
          done_r <= 1'b1;
        end else begin
          run_r <= 1'b1;
        end
      end else if (wr_en) begin
        run_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // unit payload: operand and result word capture, shift, double-and-add, divide
  always_ff @(posedge clk) begin
    if (cmd.go) begin
      op_r  <= cmd.op;
      dst_r <= cmd.dst;
      num_r <= v1;
      den_r <= v2;
      rem_r <= '0;
      cnt_r <= '0;
      ph_r  <= 1'b0;
      ox_r   <= v1;
      oy_r   <= v2;
      oinf_r <= cmd.res_inf;
      ost_r  <= cmd.res_st;
    end else if (run_r && !wr_en) begin
      case (op_r)
        ecpad_pkg::OP_MUL: begin
          if (!ph_r) begin
            rem_r <= ecpad_pkg::fadd(rem_r, rem_r, m_r);
            ph_r  <= 1'b1;
          end else begin
            if (num_r[W-1]) rem_r <= ecpad_pkg::fadd(rem_r, den_r, m_r);
            num_r <= {num_r[W-2:0], 1'b0};
            cnt_r <= cnt_r + 1'b1;
            ph_r  <= 1'b0;
          end
        end
        ecpad_pkg::OP_DIV, ecpad_pkg::OP_RED: begin
          rem_r <= div_ge ? W'(div_t - {1'b0, den_r}) : div_t[W-1:0];
          num_r <= {num_r[W-2:0], div_ge};
          cnt_r <= cnt_r + 1'b1;
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r  <= cfg_modulus & ecpad_pkg::FIELD_MASK;
      a_r  <= cfg_coef_a & ecpad_pkg::FIELD_MASK;
      b_r  <= cfg_coef_b & ecpad_pkg::FIELD_MASK;
      px_r <= in_p_x & ecpad_pkg::FIELD_MASK;
      py_r <= in_p_y & ecpad_pkg::FIELD_MASK;
      qx_r <= in_q_x & ecpad_pkg::FIELD_MASK;
      qy_r <= in_q_y & ecpad_pkg::FIELD_MASK;
    end else if (wr_en) begin
      case (dst_r)
        ecpad_pkg::RI_A:   a_r   <= res;
        ecpad_pkg::RI_B:   b_r   <= res;
        ecpad_pkg::RI_PX:  px_r  <= res;
        ecpad_pkg::RI_PY:  py_r  <= res;
        ecpad_pkg::RI_QX:  qx_r  <= res;
        ecpad_pkg::RI_QY:  qy_r  <= res;
        ecpad_pkg::RI_T0:  t0_r  <= res;
        ecpad_pkg::RI_T1:  t1_r  <= res;
        ecpad_pkg::RI_T2:  t2_r  <= res;
        ecpad_pkg::RI_R0:  r0_r  <= res;
        ecpad_pkg::RI_R1:  r1_r  <= res;
        ecpad_pkg::RI_U0:  u0_r  <= res;
        ecpad_pkg::RI_U1:  u1_r  <= res;
        ecpad_pkg::RI_Q:   q_r   <= res;
        ecpad_pkg::RI_TMP: tmp_r <= res;
        default: ;
      endcase
    end
    if (wr_q) q_r <= num_r;
  end

  assign out_valid         = ov_r;
  assign out_r_x           = ox_r;
  assign out_r_y           = oy_r;
  assign out_r_at_infinity = oinf_r;
  assign out_status        = ost_r;

endmodule

// ===== rtl/ecpad_ctrl.sv =====
`timescale 1ns / 1ps
module ecpad_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            in_opcode,
  input  logic            in_p_at_infinity,
  input  logic            in_q_at_infinity,
  output logic            busy,
  output ecpad_pkg::cmd_t cmd,
  input  ecpad_pkg::sts_t sts
);

  localparam logic [5:0] S_IDLE = 6'd0,  S_CHKM = 6'd1,  S_RA   = 6'd2,  S_RB   = 6'd3,
                         S_RPX  = 6'd4,  S_RPY  = 6'd5,  S_RQX  = 6'd6,  S_RQY  = 6'd7,
                         S_CK0  = 6'd8,  S_CK1  = 6'd9,  S_CK2  = 6'd10, S_CK3  = 6'd11,
                         S_CK4  = 6'd12, S_CK5  = 6'd13, S_CK6  = 6'd14, S_POK  = 6'd15,
                         S_QOK  = 6'd16, S_AD0  = 6'd17, S_AD1  = 6'd18, S_AD2  = 6'd19,
                         S_AD3  = 6'd20, S_AD4  = 6'd21, S_AD5  = 6'd22, S_DB0  = 6'd23,
                         S_DB1  = 6'd24, S_DB2  = 6'd25, S_DB3  = 6'd26, S_DB4  = 6'd27,
                         S_DB5  = 6'd28, S_IV0  = 6'd29, S_IV1  = 6'd30, S_IV2  = 6'd31,
                         S_IV3  = 6'd32, S_IV4  = 6'd33, S_IV5  = 6'd34, S_IV6  = 6'd35,
                         S_IV7  = 6'd36, S_IV8  = 6'd37, S_IV9  = 6'd38, S_IV10 = 6'd39,
                         S_IV11 = 6'd40, S_IV12 = 6'd41, S_IVE  = 6'd42, S_LM   = 6'd43,
                         S_FN0  = 6'd44, S_FN1  = 6'd45, S_FN2  = 6'd46, S_FN3  = 6'd47,
                         S_FN4  = 6'd48, S_FN5  = 6'd49, S_OR   = 6'd50, S_OINF = 6'd51,
                         S_OP   = 6'd52, S_OQ   = 6'd53, S_OE1  = 6'd54, S_OE2  = 6'd55,
                         S_OE3  = 6'd56;

  logic [5:0] state_r, state_nxt, nxt_op;
  logic       issued_r, issued_nxt;
  logic       dbl_r, pinf_r, qinf_r;
  logic       chkq_r, chkq_nxt, finq_r, finq_nxt;
  logic       is_op;
  logic [4:0] cx, cy, x2;

  assign busy = (state_r != S_IDLE);
  assign cx   = chkq_r ? ecpad_pkg::RI_QX : ecpad_pkg::RI_PX;
  assign cy   = chkq_r ? ecpad_pkg::RI_QY : ecpad_pkg::RI_PY;
  assign x2   = finq_r ? ecpad_pkg::RI_QX : ecpad_pkg::RI_PX;

  function automatic ecpad_pkg::cmd_t mk(input logic [2:0] op, input logic [4:0] dst,
                                         input logic [4:0] s1, input logic [4:0] s2);
    ecpad_pkg::cmd_t c;
    c        = '0;
    c.op     = op;
    c.dst    = dst;
    c.s1     = s1;
    c.s2     = s2;
    return c;
  endfunction

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    issued_nxt = issued_r;
    chkq_nxt   = chkq_r;
    finq_nxt   = finq_r;
    nxt_op     = S_IDLE;
    is_op      = 1'b1;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        is_op    = 1'b0;
        cmd.load = start;
        if (start) state_nxt = S_CHKM;
      end
      S_CHKM: begin
        is_op     = 1'b0;
        state_nxt = sts.m_lt2 ? S_OE3 : S_RA;
      end
      // reduce everything mod p
      S_RA:  begin cmd = mk(ecpad_pkg::OP_RED, ecpad_pkg::RI_A,  ecpad_pkg::RI_A,  ecpad_pkg::RI_M);
               nxt_op = S_RB; end
      S_RB:  begin cmd = mk(ecpad_pkg::OP_RED, ecpad_pkg::RI_B,  ecpad_pkg::RI_B,  ecpad_pkg::RI_M);
               nxt_op = S_RPX; end
      S_RPX: begin cmd = mk(ecpad_pkg::OP_RED, ecpad_pkg::RI_PX, ecpad_pkg::RI_PX, ecpad_pkg::RI_M);
               nxt_op = S_RPY; end
      S_RPY: begin cmd = mk(ecpad_pkg::OP_RED, ecpad_pkg::RI_PY, ecpad_pkg::RI_PY, ecpad_pkg::RI_M);
               nxt_op = S_RQX; end
      S_RQX: begin cmd = mk(ecpad_pkg::OP_RED, ecpad_pkg::RI_QX, ecpad_pkg::RI_QX, ecpad_pkg::RI_M);
               nxt_op = S_RQY; end
      S_RQY: begin
        cmd      = mk(ecpad_pkg::OP_RED, ecpad_pkg::RI_QY, ecpad_pkg::RI_QY, ecpad_pkg::RI_M);
        chkq_nxt = 1'b0;
        nxt_op   = pinf_r ? S_POK : S_CK0;
      end
      // curve equation check
      S_CK0: begin cmd = mk(ecpad_pkg::OP_MUL, ecpad_pkg::RI_T0, cy, cy); nxt_op = S_CK1; end
      S_CK1: begin cmd = mk(ecpad_pkg::OP_MUL, ecpad_pkg::RI_T1, cx, cx); nxt_op = S_CK2; end
      S_CK2: begin cmd = mk(ecpad_pkg::OP_MUL, ecpad_pkg::RI_T1, ecpad_pkg::RI_T1, cx);
               nxt_op = S_CK3; end
      S_CK3: begin cmd = mk(ecpad_pkg::OP_MUL, ecpad_pkg::RI_T2, ecpad_pkg::RI_A, cx);
               nxt_op = S_CK4; end
      S_CK4: begin cmd = mk(ecpad_pkg::OP_ADD, ecpad_pkg::RI_T1, ecpad_pkg::RI_T1, ecpad_pkg::RI_T2);
               nxt_op = S_CK5; end
      S_CK5: begin cmd = mk(ecpad_pkg::OP_ADD, ecpad_pkg::RI_T1, ecpad_pkg::RI_T1, ecpad_pkg::RI_B);
               nxt_op = S_CK6; end
      S_CK6: begin
        is_op  = 1'b0;
        cmd.s1 = ecpad_pkg::RI_T0;
        cmd.s2 = ecpad_pkg::RI_T1;
        if (sts.eq) state_nxt = chkq_r ? S_QOK : S_POK;
        else        state_nxt = chkq_r ? S_OE2 : S_OE1;
      end
      // case split after P is known good
      S_POK: begin
        is_op = 1'b0;
        if (dbl_r)        state_nxt = pinf_r ? S_OINF : S_DB0;
        else if (!qinf_r) begin
          chkq_nxt  = 1'b1;
          state_nxt = S_CK0;
        end else          state_nxt = S_QOK;
      end
      S_QOK: begin
        is_op = 1'b0;
        if (pinf_r)      state_nxt = qinf_r ? S_OINF : S_OQ;
        else if (qinf_r) state_nxt = S_OP;
        else             state_nxt = S_AD0;
      end
      // addition
      S_AD0: begin cmd = mk(ecpad_pkg::OP_SUB, ecpad_pkg::RI_T0, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_QY);
               nxt_op = S_AD1; end
      S_AD1: begin
        is_op = 1'b0; cmd.s1 = ecpad_pkg::RI_PX; cmd.s2 = ecpad_pkg::RI_QX;
        state_nxt = sts.eq ? S_AD2 : S_AD4;
      end
      S_AD2: begin
        is_op = 1'b0; cmd.s1 = ecpad_pkg::RI_PY; cmd.s2 = ecpad_pkg::RI_T0;
        state_nxt = sts.eq ? S_OINF : S_AD3;
      end
      S_AD3: begin
        is_op = 1'b0; cmd.s1 = ecpad_pkg::RI_PY; cmd.s2 = ecpad_pkg::RI_QY;
        state_nxt = sts.eq ? S_DB0 : S_AD4;
      end
      S_AD4: begin cmd = mk(ecpad_pkg::OP_SUB, ecpad_pkg::RI_T0, ecpad_pkg::RI_QX, ecpad_pkg::RI_PX);
               nxt_op = S_AD5; end
      S_AD5: begin
        cmd      = mk(ecpad_pkg::OP_SUB, ecpad_pkg::RI_T1, ecpad_pkg::RI_QY, ecpad_pkg::RI_PY);
        finq_nxt = 1'b1;
        nxt_op   = S_IV0;
      end
      // doubling
      S_DB0: begin
        is_op = 1'b0; cmd.s1 = ecpad_pkg::RI_PY; cmd.s2 = ecpad_pkg::RI_ZERO;
        state_nxt = sts.eq ? S_OINF : S_DB1;
      end
      S_DB1: begin cmd = mk(ecpad_pkg::OP_MUL, ecpad_pkg::RI_T0, ecpad_pkg::RI_PX, ecpad_pkg::RI_PX);
               nxt_op = S_DB2; end
      S_DB2: begin cmd = mk(ecpad_pkg::OP_ADD, ecpad_pkg::RI_T1, ecpad_pkg::RI_T0, ecpad_pkg::RI_T0);
               nxt_op = S_DB3; end
      S_DB3: begin cmd = mk(ecpad_pkg::OP_ADD, ecpad_pkg::RI_T1, ecpad_pkg::RI_T1, ecpad_pkg::RI_T0);
               nxt_op = S_DB4; end
      S_DB4: begin cmd = mk(ecpad_pkg::OP_ADD, ecpad_pkg::RI_T1, ecpad_pkg::RI_T1, ecpad_pkg::RI_A);
               nxt_op = S_DB5; end
      S_DB5: begin
        cmd      = mk(ecpad_pkg::OP_ADD, ecpad_pkg::RI_T0, ecpad_pkg::RI_PY, ecpad_pkg::RI_PY);
        finq_nxt = 1'b0;
        nxt_op   = S_IV0;
      end
      // extended euclid on T0, inverse left in U0
      S_IV0: begin cmd = mk(ecpad_pkg::OP_MOV, ecpad_pkg::RI_R0, ecpad_pkg::RI_M, ecpad_pkg::RI_ZERO);
               nxt_op = S_IV1; end
      S_IV1: begin cmd = mk(ecpad_pkg::OP_MOV, ecpad_pkg::RI_R1, ecpad_pkg::RI_T0, ecpad_pkg::RI_ZERO);
               nxt_op = S_IV2; end
      S_IV2: begin cmd = mk(ecpad_pkg::OP_MOV, ecpad_pkg::RI_U0, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_ZERO);
               nxt_op = S_IV3; end
      S_IV3: begin cmd = mk(ecpad_pkg::OP_MOV, ecpad_pkg::RI_U1, ecpad_pkg::RI_ONE, ecpad_pkg::RI_ZERO);
               nxt_op = S_IV4; end
      S_IV4: begin
        is_op = 1'b0; cmd.s1 = ecpad_pkg::RI_R1; cmd.s2 = ecpad_pkg::RI_ZERO;
        state_nxt = sts.eq ? S_IVE : S_IV5;
      end
      S_IV5:  begin cmd = mk(ecpad_pkg::OP_DIV, ecpad_pkg::RI_TMP, ecpad_pkg::RI_R0, ecpad_pkg::RI_R1);
                nxt_op = S_IV6; end
      S_IV6:  begin cmd = mk(ecpad_pkg::OP_MOV, ecpad_pkg::RI_R0, ecpad_pkg::RI_R1, ecpad_pkg::RI_ZERO);
                nxt_op = S_IV7; end
      S_IV7:  begin cmd = mk(ecpad_pkg::OP_MOV, ecpad_pkg::RI_R1, ecpad_pkg::RI_TMP, ecpad_pkg::RI_ZERO);
                nxt_op = S_IV8; end
      S_IV8:  begin cmd = mk(ecpad_pkg::OP_RED, ecpad_pkg::RI_Q, ecpad_pkg::RI_Q, ecpad_pkg::RI_M);
                nxt_op = S_IV9; end
      S_IV9:  begin cmd = mk(ecpad_pkg::OP_MUL, ecpad_pkg::RI_TMP, ecpad_pkg::RI_Q, ecpad_pkg::RI_U1);
                nxt_op = S_IV10; end
      S_IV10: begin cmd = mk(ecpad_pkg::OP_SUB, ecpad_pkg::RI_TMP, ecpad_pkg::RI_U0, ecpad_pkg::RI_TMP);
                nxt_op = S_IV11; end
      S_IV11: begin cmd = mk(ecpad_pkg::OP_MOV, ecpad_pkg::RI_U0, ecpad_pkg::RI_U1, ecpad_pkg::RI_ZERO);
                nxt_op = S_IV12; end
      S_IV12: begin cmd = mk(ecpad_pkg::OP_MOV, ecpad_pkg::RI_U1, ecpad_pkg::RI_TMP, ecpad_pkg::RI_ZERO);
                nxt_op = S_IV4; end
      S_IVE: begin
        is_op = 1'b0; cmd.s1 = ecpad_pkg::RI_R0; cmd.s2 = ecpad_pkg::RI_ONE;
        state_nxt = sts.eq ? S_LM : S_OE3;
      end
      // slope and new point
      S_LM:  begin cmd = mk(ecpad_pkg::OP_MUL, ecpad_pkg::RI_T2, ecpad_pkg::RI_T1, ecpad_pkg::RI_U0);
               nxt_op = S_FN0; end
      S_FN0: begin cmd = mk(ecpad_pkg::OP_MUL, ecpad_pkg::RI_T0, ecpad_pkg::RI_T2, ecpad_pkg::RI_T2);
               nxt_op = S_FN1; end
      S_FN1: begin cmd = mk(ecpad_pkg::OP_SUB, ecpad_pkg::RI_T0, ecpad_pkg::RI_T0, ecpad_pkg::RI_PX);
               nxt_op = S_FN2; end
      S_FN2: begin cmd = mk(ecpad_pkg::OP_SUB, ecpad_pkg::RI_T0, ecpad_pkg::RI_T0, x2);
               nxt_op = S_FN3; end
      S_FN3: begin cmd = mk(ecpad_pkg::OP_SUB, ecpad_pkg::RI_T1, ecpad_pkg::RI_PX, ecpad_pkg::RI_T0);
               nxt_op = S_FN4; end
      S_FN4: begin cmd = mk(ecpad_pkg::OP_MUL, ecpad_pkg::RI_T1, ecpad_pkg::RI_T2, ecpad_pkg::RI_T1);
               nxt_op = S_FN5; end
      S_FN5: begin cmd = mk(ecpad_pkg::OP_SUB, ecpad_pkg::RI_T1, ecpad_pkg::RI_T1, ecpad_pkg::RI_PY);
               nxt_op = S_OR; end
      // result words
      S_OR:   cmd = mk(ecpad_pkg::OP_OUT, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_T0, ecpad_pkg::RI_T1);
      S_OP:   cmd = mk(ecpad_pkg::OP_OUT, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_PX, ecpad_pkg::RI_PY);
      S_OQ:   cmd = mk(ecpad_pkg::OP_OUT, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_QX, ecpad_pkg::RI_QY);
      S_OINF: begin
        cmd = mk(ecpad_pkg::OP_OUT, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_ZERO);
        cmd.res_inf = 1'b1;
      end
      S_OE1: begin
        cmd = mk(ecpad_pkg::OP_OUT, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_ZERO);
        cmd.res_st = ecpad_pkg::ST_P_OFF;
      end
      S_OE2: begin
        cmd = mk(ecpad_pkg::OP_OUT, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_ZERO);
        cmd.res_st = ecpad_pkg::ST_Q_OFF;
      end
      S_OE3: begin
        cmd = mk(ecpad_pkg::OP_OUT, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_ZERO, ecpad_pkg::RI_ZERO);
        cmd.res_st = ecpad_pkg::ST_NOINV;
      end
      default: begin
        is_op     = 1'b0;
        state_nxt = S_IDLE;
      end
    endcase
    // issue once, then wait for the unit
    if (is_op) begin
      cmd.go     = !issued_r;
      issued_nxt = !sts.done;
      if (sts.done) state_nxt = nxt_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      issued_r <= 1'b0;
      chkq_r   <= 1'b0;
      finq_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      issued_r <= issued_nxt;
      chkq_r   <= chkq_nxt;
      finq_r   <= finq_nxt;
    end
  end

  // item flags captured with the word
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dbl_r  <= in_opcode;
      pinf_r <= in_p_at_infinity;
      qinf_r <= in_q_at_infinity;
    end
  end

endmodule

// ===== rtl/ecpad_chk.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ecpad_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [63:0] out_r_x,
  input logic [63:0] out_r_y,
  input logic        out_r_at_infinity,
  input logic [1:0]  out_status
);

  // a result only ends a word in flight
  `ECPAD_ASSERT(a_res_busy, out_valid |-> busy, "result strobe while idle")
  // the block frees itself once the result is out
  `ECPAD_ASSERT(a_res_free, out_valid |=> !busy, "still busy after result")
  // accepted word starts work
  `ECPAD_ASSERT(a_accept, (start && !busy) |=> busy, "accepted word not taken")
  // errors carry no point
  `ECPAD_ASSERT(a_err_zero,
    (out_valid && out_status != ecpad_pkg::ST_OK) |-> (out_r_x == 64'd0 &&
    out_r_y == 64'd0 && !out_r_at_infinity), "error result not cleared")
  // identity carries zero coordinates
  `ECPAD_ASSERT(a_inf_zero,
    (out_valid && out_r_at_infinity) |-> (out_r_x == 64'd0 && out_r_y == 64'd0),
    "identity result with coordinates")

endmodule

bind elliptic_curve_point_add_double ecpad_chk u_chk (.*);
